@@ hdl/dcpl_pkg.sv @@
package dcpl_pkg;

  // Graph and length limits.
  localparam int MAX_NODES  = 16;
  localparam int MAX_LEN    = 2048;
  localparam int WEIGHT_MAX = 127;

  // Field widths of the ports.
  localparam int NODE_W = 5;
  localparam int WT_W   = 7;
  localparam int LEN_W  = 11;

  // Internal widths.
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int PAIR_W  = 2 * IDX_W;
  localparam int PAIRS   = MAX_NODES * MAX_NODES;
  localparam int WSAT_W  = $clog2(WEIGHT_MAX + 1);
  localparam int WBITS   = 64;
  localparam int SHIFT_W = $clog2(WBITS);
  localparam int WORDS   = MAX_LEN / WBITS;
  localparam int WRD_W   = $clog2(WORDS);
  localparam int RWORDS  = MAX_NODES * WORDS;
  localparam int RADDR_W = IDX_W + WRD_W;
  localparam int Q_W     = WSAT_W - SHIFT_W;

  // Configuration register map (byte addresses).
  localparam logic [2:0] REG_NODE_COUNT = 3'd0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(MAX_NODES);

  // Saturate an incoming weight to the largest weight the stores hold.
  function automatic logic [WSAT_W-1:0] sat_weight(input logic [WT_W-1:0] w);
    logic [WSAT_W-1:0] res;
    if (int'(w) > WEIGHT_MAX) begin
      res = WSAT_W'(WEIGHT_MAX);
    end else begin
      res = WSAT_W'(w);
    end
    return res;
  endfunction

endpackage

@@ hdl/dag_common_path_length_top.sv @@
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  from_node, to_node, weight_first,
//                                          weight_second, last_edge
// out_     output     out_valid / out_stall found, meeting_length
// cfg      APB write  psel/penable/pwrite  node_count at byte address 0
//
// Edges load one per cycle while the block is in its load state; the weight stores
// update by read, compare and write with forwarding of the last written entry.
// After the last edge the block drains, then walks each forward node pair,
// reading its weights and, for a pair with an edge, passing one 64-bit reach
// word a cycle; then it scans the destination row and fills the result register
// before the result is offered. Reset is synchronous; the reach memories need
// no clearing pass since each node row carries a written flag. A stalled result
// holds while the next graph loads; its own answer waits for the slot.
module dag_common_path_length_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dcpl_pkg::NODE_W-1:0]   in_from_node,
  input  logic [dcpl_pkg::NODE_W-1:0]   in_to_node,
  input  logic [dcpl_pkg::WT_W-1:0]     in_weight_first,
  input  logic [dcpl_pkg::WT_W-1:0]     in_weight_second,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [dcpl_pkg::LEN_W-1:0]    out_meeting_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W   = dcpl_pkg::IDX_W;
  localparam int WSAT_W  = dcpl_pkg::WSAT_W;
  localparam int WBITS   = dcpl_pkg::WBITS;
  localparam int WRD_W   = dcpl_pkg::WRD_W;
  localparam int SHIFT_W = dcpl_pkg::SHIFT_W;
  localparam int NODE_W  = dcpl_pkg::NODE_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_WREAD = 4'd2;
  localparam logic [3:0] S_WGET  = 4'd3;
  localparam logic [3:0] S_PASS  = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_SEND  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [WRD_W-1:0] LAST_WORD = WRD_W'(dcpl_pkg::WORDS - 1);

  logic [3:0] state_r;
  logic [NODE_W-1:0] node_count_r;

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == dcpl_pkg::REG_NODE_COUNT);
  assign prdata = (paddr == dcpl_pkg::REG_NODE_COUNT) ? 32'(node_count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= dcpl_pkg::NODE_COUNT_RST;
    end else if (cfg_wr) begin
      node_count_r <= pwdata[NODE_W-1:0];
    end
  end

  // Clamp the node count and turn the destination into a row index.
  logic [NODE_W-1:0] n_cl;
  logic [IDX_W-1:0]  n_idx;
  always_comb begin
    if (node_count_r == '0) begin
      n_cl = NODE_W'(1);
    end else if (int'(node_count_r) > dcpl_pkg::MAX_NODES) begin
      n_cl = NODE_W'(dcpl_pkg::MAX_NODES);
    end else begin
      n_cl = node_count_r;
    end
    n_idx = IDX_W'(n_cl - NODE_W'(1));
  end

  // Input decode.
  logic in_acc;
  logic edge_ok;
  logic [dcpl_pkg::PAIR_W-1:0] in_addr;
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign edge_ok  = (in_from_node >= NODE_W'(1))
                 && (int'(in_from_node) <= dcpl_pkg::MAX_NODES)
                 && (in_to_node >= NODE_W'(1))
                 && (int'(in_to_node) <= dcpl_pkg::MAX_NODES)
                 && (in_to_node > in_from_node);
  assign in_addr  = {IDX_W'(in_from_node - NODE_W'(1)), IDX_W'(in_to_node - NODE_W'(1))};

  // Pair walk indices and word counter.
  logic [IDX_W-1:0] i_r, k_r;
  logic [WRD_W-1:0] t_r;

  // Weight stores: one entry per ordered pair, valid bits in flip-flops.
  logic [WSAT_W-1:0] wmem_a [dcpl_pkg::PAIRS];
  logic [WSAT_W-1:0] wmem_b [dcpl_pkg::PAIRS];
  logic [WSAT_W-1:0] wq_a, wq_b;
  logic [dcpl_pkg::PAIRS-1:0] wvld_r;
  logic [dcpl_pkg::PAIR_W-1:0] w_raddr;

  // Load stage holding an edge whose old weights are being read.
  logic                        ld_v_r;
  logic [dcpl_pkg::PAIR_W-1:0] ld_addr_r;
  logic [WSAT_W-1:0]           ld_wa_r, ld_wb_r;
  logic                        fw_v_r;
  logic [dcpl_pkg::PAIR_W-1:0] fw_addr_r;
  logic [WSAT_W-1:0]           fw_wa_r, fw_wb_r;
  logic [WSAT_W-1:0]           old_a, old_b, new_a, new_b;
  logic                        fw_hit;

  assign w_raddr = (state_r == S_LOAD) ? in_addr : {i_r, k_r};

  always_comb begin
    fw_hit = fw_v_r && (fw_addr_r == ld_addr_r);
    old_a  = fw_hit ? fw_wa_r : wq_a;
    old_b  = fw_hit ? fw_wb_r : wq_b;
    new_a  = (!wvld_r[ld_addr_r] || (ld_wa_r < old_a)) ? ld_wa_r : old_a;
    new_b  = (!wvld_r[ld_addr_r] || (ld_wb_r < old_b)) ? ld_wb_r : old_b;
  end

  always_ff @(posedge clk) begin
    wq_a <= wmem_a[w_raddr];
    wq_b <= wmem_b[w_raddr];
    if (ld_v_r) begin
      wmem_a[ld_addr_r] <= new_a;
      wmem_b[ld_addr_r] <= new_b;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r <= in_addr;
    ld_wa_r   <= dcpl_pkg::sat_weight(in_weight_first);
    ld_wb_r   <= dcpl_pkg::sat_weight(in_weight_second);
    if (ld_v_r) begin
      fw_addr_r <= ld_addr_r;
      fw_wa_r   <= new_a;
      fw_wb_r   <= new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_v_r <= 1'b0;
      fw_v_r <= 1'b0;
    end else begin
      ld_v_r <= in_acc && edge_ok;
      if (ld_v_r) begin
        fw_v_r <= 1'b1;
      end
    end
  end

  // Edge under work in the reach pass.
  localparam int Q_W_F = dcpl_pkg::Q_W;
  logic              va_r, vb_r;
  logic [WSAT_W-1:0] da_r, db_r;
  logic [Q_W_F-1:0]  qa, qb;
  logic [WRD_W:0]    sa_full, sb_full;

  assign qa      = da_r[WSAT_W-1:SHIFT_W];
  assign qb      = db_r[WSAT_W-1:SHIFT_W];
  assign sa_full = {1'b0, t_r} - (WRD_W + 1)'(qa);
  assign sb_full = {1'b0, t_r} - (WRD_W + 1)'(qb);

  // Reach memories: one 64-bit word of lengths per address, rows per node.
  logic [WBITS-1:0] rmem_a [dcpl_pkg::RWORDS];
  logic [WBITS-1:0] rmem_b [dcpl_pkg::RWORDS];
  logic [WBITS-1:0] rq0_a, rq1_a, rq0_b, rq1_b;
  logic [dcpl_pkg::RADDR_W-1:0] ra0_a, ra0_b, ra1;
  logic [dcpl_pkg::RADDR_W-1:0] r_waddr;
  logic [WBITS-1:0] wdat_a, wdat_b;
  logic             r_we;

  always_comb begin
    if (state_r == S_SCAN) begin
      ra0_a = {n_idx, t_r};
      ra0_b = {n_idx, t_r};
    end else begin
      ra0_a = {i_r, sa_full[WRD_W-1:0]};
      ra0_b = {i_r, sb_full[WRD_W-1:0]};
    end
    ra1 = {k_r, t_r};
  end

  always_ff @(posedge clk) begin
    rq0_a <= rmem_a[ra0_a];
    rq1_a <= rmem_a[ra1];
    rq0_b <= rmem_b[ra0_b];
    rq1_b <= rmem_b[ra1];
    if (r_we) begin
      rmem_a[r_waddr] <= wdat_a;
      rmem_b[r_waddr] <= wdat_b;
    end
  end

  // Rows written since the last answer; an unwritten row is read as its reset value.
  logic [dcpl_pkg::MAX_NODES-1:0] row_ok_r;

  // Pass pipeline: read in one cycle, shift, merge and write in the next.
  logic             pp_v_r;
  logic [WRD_W-1:0] pp_t_r;
  logic             pa_neg_r, pb_neg_r, pa_zero_r, pb_zero_r;
  logic [WBITS-1:0] prev_a_r, prev_b_r;
  logic [WBITS-1:0] src_a, src_b, tgt_a, tgt_b;
  logic [2*WBITS-1:0] sh_a, sh_b;

  always_comb begin
    if (pa_neg_r) begin
      src_a = '0;
    end else if (row_ok_r[i_r]) begin
      src_a = rq0_a;
    end else begin
      src_a = WBITS'((i_r == '0) && pa_zero_r);
    end
    if (pb_neg_r) begin
      src_b = '0;
    end else if (row_ok_r[i_r]) begin
      src_b = rq0_b;
    end else begin
      src_b = WBITS'((i_r == '0) && pb_zero_r);
    end
    tgt_a   = row_ok_r[k_r] ? rq1_a : '0;
    tgt_b   = row_ok_r[k_r] ? rq1_b : '0;
    sh_a    = {src_a, prev_a_r} << da_r[SHIFT_W-1:0];
    sh_b    = {src_b, prev_b_r} << db_r[SHIFT_W-1:0];
    wdat_a  = tgt_a | (va_r ? sh_a[2*WBITS-1:WBITS] : '0);
    wdat_b  = tgt_b | (vb_r ? sh_b[2*WBITS-1:WBITS] : '0);
    r_we    = pp_v_r;
    r_waddr = {k_r, pp_t_r};
  end

  // Final scan of the destination row for the first common length.
  logic               sc_v_r;
  logic [WRD_W-1:0]   sc_t_r;
  logic [WBITS-1:0]   sc_a, sc_b, both;
  logic [SHIFT_W-1:0] low_bit;
  logic               fnd_r;
  logic [dcpl_pkg::LEN_W-1:0] len_r;

  always_comb begin
    if (row_ok_r[n_idx]) begin
      sc_a = rq0_a;
      sc_b = rq0_b;
    end else begin
      sc_a = WBITS'((n_idx == '0) && (sc_t_r == '0));
      sc_b = WBITS'((n_idx == '0) && (sc_t_r == '0));
    end
    both    = sc_a & sc_b;
    low_bit = '0;
    for (int b = WBITS - 1; b >= 0; b--) begin
      if (both[b]) begin
        low_bit = SHIFT_W'(b);
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    pp_t_r    <= t_r;
    pa_neg_r  <= sa_full[WRD_W];
    pb_neg_r  <= sb_full[WRD_W];
    pa_zero_r <= (sa_full == '0);
    pb_zero_r <= (sb_full == '0);
    sc_t_r    <= t_r;
    if (state_r == S_WGET) begin
      va_r     <= wvld_r[{i_r, k_r}];
      vb_r     <= wvld_r[{i_r, k_r}];
      da_r     <= wq_a;
      db_r     <= wq_b;
      prev_a_r <= '0;
      prev_b_r <= '0;
    end else if (pp_v_r) begin
      prev_a_r <= src_a;
      prev_b_r <= src_b;
    end
    if (sc_v_r && !fnd_r && (both != '0)) begin
      len_r <= {sc_t_r, low_bit};
    end
  end

  // Sequencer, flags and result register.
  logic out_valid_r, out_found_r;
  logic [dcpl_pkg::LEN_W-1:0] out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      i_r         <= '0;
      k_r         <= '0;
      t_r         <= '0;
      wvld_r      <= '0;
      row_ok_r    <= '0;
      pp_v_r      <= 1'b0;
      sc_v_r      <= 1'b0;
      fnd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      pp_v_r <= (state_r == S_PASS);
      sc_v_r <= (state_r == S_SCAN);
      if (ld_v_r) begin
        wvld_r[ld_addr_r] <= 1'b1;
      end
      if (pp_v_r && (pp_t_r == LAST_WORD)) begin
        row_ok_r[k_r] <= 1'b1;
      end
      if (sc_v_r && (both != '0)) begin
        fnd_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc && in_last_edge) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          i_r   <= '0;
          k_r   <= IDX_W'(1);
          t_r   <= '0;
          fnd_r <= 1'b0;
          state_r <= (n_idx == '0) ? S_SCAN : S_WREAD;
        end
        S_WREAD: begin
          state_r <= S_WGET;
        end
        S_WGET: begin
          t_r <= '0;
          state_r <= wvld_r[{i_r, k_r}] ? S_PASS : S_NEXT;
        end
        S_PASS: begin
          t_r <= t_r + WRD_W'(1);
          if (t_r == LAST_WORD) begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          t_r <= '0;
          if (k_r == n_idx) begin
            if (IDX_W'(i_r + IDX_W'(1)) == n_idx) begin
              state_r <= S_SCAN;
            end else begin
              i_r     <= i_r + IDX_W'(1);
              k_r     <= i_r + IDX_W'(2);
              state_r <= S_WREAD;
            end
          end else begin
            k_r     <= k_r + IDX_W'(1);
            state_r <= S_WREAD;
          end
        end
        S_SCAN: begin
          t_r <= t_r + WRD_W'(1);
          if (t_r == LAST_WORD) begin
            state_r <= S_SEND;
          end
        end
        S_SEND: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_found_r <= fnd_r;
            wvld_r      <= '0;
            row_ok_r    <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // The length register needs no reset; it is qualified by the found flag.
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
      out_len_r <= fnd_r ? len_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_meeting_length = out_len_r;

endmodule

@@ tb/dcpl_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts each answer and compares it with the block.
module dcpl_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [dcpl_pkg::NODE_W-1:0]   in_from_node,
  input  logic [dcpl_pkg::NODE_W-1:0]   in_to_node,
  input  logic [dcpl_pkg::WT_W-1:0]     in_weight_first,
  input  logic [dcpl_pkg::WT_W-1:0]     in_weight_second,
  input  logic                          in_last_edge,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_found,
  input  logic [dcpl_pkg::LEN_W-1:0]    out_meeting_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            answers_pending
);

  typedef struct packed {
    logic                       found;
    logic [dcpl_pkg::LEN_W-1:0] length;
  } answer_t;

  localparam int NSLOT = dcpl_pkg::MAX_NODES + 1;

  logic [dcpl_pkg::NODE_W-1:0] node_limit;
  int                wt_a[NSLOT][NSLOT];
  int                wt_b[NSLOT][NSLOT];
  bit                reach_a[NSLOT][dcpl_pkg::MAX_LEN];
  bit                reach_b[NSLOT][dcpl_pkg::MAX_LEN];
  answer_t           answer_q[$];

  // Weight value -1 marks a pair with no edge.
  function automatic void clear_graph();
    for (int i = 0; i < NSLOT; i++) begin
      for (int k = 0; k < NSLOT; k++) begin
        wt_a[i][k] = -1;
        wt_b[i][k] = -1;
      end
      for (int j = 0; j < dcpl_pkg::MAX_LEN; j++) begin
        reach_a[i][j] = 0;
        reach_b[i][j] = 0;
      end
    end
    reach_a[1][0] = 1;
    reach_b[1][0] = 1;
  endfunction

  // Walk nodes in order, spread reachable lengths, then find the first shared one.
  function automatic answer_t solve_common_length();
    answer_t res;
    int n;
    int da;
    int db;
    n = node_limit;
    if (n < 1) n = 1;
    if (n > dcpl_pkg::MAX_NODES) n = dcpl_pkg::MAX_NODES;
    for (int i = 1; i < n; i++) begin
      for (int k = i + 1; k <= n; k++) begin
        da = wt_a[i][k];
        db = wt_b[i][k];
        for (int j = 0; j < dcpl_pkg::MAX_LEN; j++) begin
          if (da >= 0 && reach_a[i][j] && j + da < dcpl_pkg::MAX_LEN) reach_a[k][j + da] = 1;
          if (db >= 0 && reach_b[i][j] && j + db < dcpl_pkg::MAX_LEN) reach_b[k][j + db] = 1;
        end
      end
    end
    res = '0;
    for (int j = 0; j < dcpl_pkg::MAX_LEN; j++) begin
      if (reach_a[n][j] && reach_b[n][j]) begin
        res.found = 1'b1;
        res.length = dcpl_pkg::LEN_W'(j);
        break;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    int u;
    int v;
    int wa;
    int wb;
    answer_t got;
    answer_t exp_ans;
    if (!rst_n) begin
      node_limit <= dcpl_pkg::NODE_COUNT_RST;
      clear_graph();
      answer_q.delete();
      fail_count <= 0;
      answers_pending <= 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready && paddr == dcpl_pkg::REG_NODE_COUNT) begin
        node_limit <= pwdata[dcpl_pkg::NODE_W-1:0];
      end
      // Accepted edge.
      if (in_valid && !in_stall) begin
        u = in_from_node;
        v = in_to_node;
        wa = in_weight_first > dcpl_pkg::WEIGHT_MAX ? dcpl_pkg::WEIGHT_MAX : in_weight_first;
        wb = in_weight_second > dcpl_pkg::WEIGHT_MAX ? dcpl_pkg::WEIGHT_MAX : in_weight_second;
        if (u >= 1 && v <= dcpl_pkg::MAX_NODES && v > u) begin
          if (wt_a[u][v] < 0 || wa < wt_a[u][v]) wt_a[u][v] = wa;
          if (wt_b[u][v] < 0 || wb < wt_b[u][v]) wt_b[u][v] = wb;
        end
        if (in_last_edge) begin
          answer_q.push_back(solve_common_length());
          clear_graph();
        end
      end
      // Accepted answer.
      if (out_valid && !out_stall) begin
        got.found = out_found;
        got.length = out_meeting_length;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer found=%0d length=%0d", $time,
                   got.found, got.length);
          fail_count <= fail_count + 1;
        end else begin
          exp_ans = answer_q.pop_front();
          if (got.found !== exp_ans.found) begin
            $display("%0t: found expected %0d actual %0d", $time,
                     exp_ans.found, got.found);
            fail_count <= fail_count + 1;
          end else if (got.length !== exp_ans.length) begin
            $display("%0t: meeting_length expected %0d actual %0d", $time,
                     exp_ans.length, got.length);
            fail_count <= fail_count + 1;
          end
        end
      end
      answers_pending <= answer_q.size();
    end
  end

endmodule

@@ tb/tb_dag_common_path_length_top.sv @@
`timescale 1ns / 1ps

module tb_dag_common_path_length_top;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [dcpl_pkg::NODE_W-1:0]   in_from_node;
  logic [dcpl_pkg::NODE_W-1:0]   in_to_node;
  logic [dcpl_pkg::WT_W-1:0]     in_weight_first;
  logic [dcpl_pkg::WT_W-1:0]     in_weight_second;
  logic                          in_last_edge;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_found;
  logic [dcpl_pkg::LEN_W-1:0]    out_meeting_length;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  int                            fail_count;
  int                            answers_pending;
  int                            hold_off_cycles;
  logic [dcpl_pkg::NODE_W-1:0]   graph_size;

  dag_common_path_length_top u_dut (.*);

  dcpl_checker u_checker (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Generous limit: ~1900 items plus about 80 answers, each with its full pair walk.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, with one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles = hold_off_cycles - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one edge and wait for it to be taken; the gap before it is random.
  // Valid stays high into the next edge when there is no gap, and drops after
  // the last edge of a graph.
  task automatic send_edge(input int u, input int v, input int wa, input int wb,
                           input bit last);
    int gap;
    gap = 0;
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_from_node <= dcpl_pkg::NODE_W'(u);
    in_to_node <= dcpl_pkg::NODE_W'(v);
    in_weight_first <= dcpl_pkg::WT_W'(wa);
    in_weight_second <= dcpl_pkg::WT_W'(wb);
    in_last_edge <= last;
    do @(posedge clk); while (in_stall);
    if (last) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_node_count(input int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= dcpl_pkg::REG_NODE_COUNT;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Let every answer come out, then allow for a walk still under way.
  task automatic wait_idle();
    @(posedge clk);
    while (answers_pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // One random graph: mostly forward edges inside the node range, some noise.
  task automatic send_graph(input int nodes, input int edges);
    int u;
    int v;
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        u = $urandom_range(0, 31);
        v = $urandom_range(0, 31);
      end else begin
        u = $urandom_range(1, (nodes > 1) ? nodes - 1 : 1);
        v = $urandom_range(u + 1, (nodes > u) ? nodes : u + 1);
      end
      send_edge(u, v, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 20),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, 20),
                e == edges - 1);
    end
  endtask

  initial begin
    int items;
    int nodes;
    int edges;
    bit held;
    hold_off_cycles = 0;
    held = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_from_node = '0;
    in_to_node = '0;
    in_weight_first = '0;
    in_weight_second = '0;
    in_last_edge = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default 16 nodes, chain with extreme weights, duplicates,
    // backward, self and out-of-range edges.
    send_edge(1, 16, 127, 127, 0);
    send_edge(1, 16, 5, 9, 0);
    send_edge(1, 16, 9, 5, 0);
    send_edge(3, 2, 1, 1, 0);
    send_edge(4, 4, 1, 1, 0);
    send_edge(0, 5, 1, 1, 0);
    send_edge(2, 17, 1, 1, 0);
    send_edge(31, 31, 0, 0, 0);
    send_edge(1, 2, 4, 0, 0);
    send_edge(2, 16, 0, 4, 1);
    // Long sums that stay under the length limit, no common length.
    for (int i = 1; i < 16; i++) send_edge(i, i + 1, 127, (i == 15) ? 126 : 127, 0);
    send_edge(1, 16, 0, 1, 1);
    wait_idle();

    // Single node, zero and oversized node counts.
    write_node_count(1);
    send_edge(1, 2, 3, 3, 1);
    wait_idle();
    write_node_count(0);
    send_edge(1, 3, 3, 3, 1);
    wait_idle();
    write_node_count(31);
    send_edge(1, 16, 7, 7, 1);
    wait_idle();

    // Random graphs over several node counts; the long hold-off early on.
    items = 0;
    while (items < 1800) begin
      nodes = $urandom_range(0, 3) == 0 ? 16 : $urandom_range(2, 8);
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        graph_size = dcpl_pkg::NODE_W'(nodes);
        write_node_count(graph_size);
      end
      if (!held && items > 100) begin
        hold_off_cycles = 3000;
        held = 1'b1;
      end
      edges = $urandom_range(1, 40);
      send_graph(nodes, edges);
      items = items + edges;
      if ($urandom_range(0, 4) == 0) wait_idle();
    end
    // Make the following node count writes safe.
    wait_idle();
    write_node_count(2);
    send_edge(1, 2, 127, 127, 1);
    wait_idle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
